// ===== hdl/chs_pkg.sv =====
// chs_pkg: types, sizes and codes shared by the chained hash set core.
// Depends on nothing; imported by every module of the block but chs_ram.
package chs_pkg;

	localparam int KEY_W       = 31;
	localparam int HANDLE_W    = 16;
	localparam int ENTRIES     = 1024;
	localparam int BUCKETS     = 1024;
	localparam int ENT_AW      = 10;            // index into the entry pool
	localparam int BKT_AW      = 10;            // index into the bucket heads
	localparam int PTR_W       = ENT_AW + 1;    // pointer with end-of-chain bit
	localparam int BC_W        = 11;
	localparam int ST_W        = 3;
	localparam int ENT_W       = KEY_W + HANDLE_W + PTR_W;

	localparam logic [PTR_W-1:0] PTR_NONE    = PTR_W'(ENTRIES);
	localparam logic [BC_W-1:0]  BC_RESET    = BC_W'(1021);
	localparam logic [BC_W-1:0]  BC_MAX      = BC_W'(BUCKETS);

	localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [ST_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [ST_W-1:0] ST_POOL_FULL = 3'd4;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic                op;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] entry_handle;
	} chs_req_t;

	typedef struct packed {
		logic [ST_W-1:0]     status;
		logic [HANDLE_W-1:0] found_handle;
	} chs_rsp_t;

	// classified job handed from front to back
	typedef struct packed {
		logic                op;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		logic [BKT_AW-1:0]   bucket;
	} chs_job_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
		logic [PTR_W-1:0]    next;
	} chs_ent_t;

endpackage

// ===== hdl/chs_ram.sv =====
// chs_ram: generic single-port RAM with registered read.
// Depends on nothing.
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== hdl/chs_front.sv =====
// chs_front: takes beats, works out the bucket with a bit-serial modulo unit
// and queues classified jobs (two deep) for the back end. Uses chs_pkg.
module chs_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  chs_pkg::chs_req_t       req,
	input  logic [chs_pkg::BC_W-1:0] divisor,
	input  logic                    clearing,
	output logic                    job_valid,
	output chs_pkg::chs_job_t       job,
	input  logic                    job_take
);
	import chs_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [4:0]        bit_q;
	logic [BC_W-1:0]   rem_q;
	chs_req_t          item_q;
	logic [BC_W:0]     trial;
	logic [BC_W:0]     diff;
	logic              accept;
	logic              enq;
	chs_job_t          q0_q, q1_q, new_job;
	logic [1:0]        qcnt_q;

	assign full   = busy_q | clearing;
	assign accept = push & ~full;
	assign enq    = busy_q & done_q & (qcnt_q != 2'd2);

	// one quotient bit per cycle, MSB first; remainder stays below divisor
	assign trial = {rem_q, item_q.key[bit_q]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			bit_q  <= 5'(KEY_W - 1);
		end else if (busy_q && !done_q) begin
			if (bit_q == 5'd0) begin
				done_q <= 1'b1;
			end else begin
				bit_q <= bit_q - 5'd1;
			end
		end else if (enq) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
			rem_q  <= '0;
		end else if (busy_q && !done_q) begin
			rem_q <= diff[BC_W] ? trial[BC_W-1:0] : diff[BC_W-1:0];
		end
	end

	always_comb begin
		new_job.op     = item_q.op;
		new_job.key    = item_q.key;
		new_job.handle = item_q.entry_handle;
		new_job.bucket = rem_q[BKT_AW-1:0];
	end

	// two-entry job queue, head in q0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= '0;
		end else begin
			qcnt_q <= qcnt_q + {1'b0, enq} - {1'b0, job_take};
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			q0_q <= (qcnt_q == 2'd2) ? q1_q : new_job;
			if (enq) begin
				q1_q <= new_job;
			end
		end else if (enq) begin
			if (qcnt_q == 2'd0) begin
				q0_q <= new_job;
			end else begin
				q1_q <= new_job;
			end
		end
	end

	assign job_valid = qcnt_q != 2'd0;
	assign job       = q0_q;

endmodule

// ===== hdl/chs_back.sv =====
// chs_back: empties the bucket heads after reset, walks bucket chains in the head and
// entry RAMs, links new entries and queues results (two deep). Uses chs_pkg and chs_ram.
module chs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  chs_pkg::chs_job_t job,
	output logic              job_take,
	output logic              clearing,
	output logic              empty,
	input  logic              pop,
	output chs_pkg::chs_rsp_t rsp
);
	import chs_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_HEAD = 2'd1;
	localparam logic [1:0] B_ENT  = 2'd2;
	localparam logic [1:0] B_FIN  = 2'd3;

	logic [1:0]          state_q;
	chs_job_t            job_q;
	logic [PTR_W-1:0]    head_q;
	logic                hit_q;
	logic [HANDLE_W-1:0] hit_handle_q;
	logic [PTR_W-1:0]    count_q;
	logic                clr_q;
	logic [BKT_AW-1:0]   clr_idx_q;

	logic                h_we;
	logic [BKT_AW-1:0]   h_addr;
	logic [PTR_W-1:0]    h_wdata, h_rdata;
	logic                e_we;
	logic [ENT_AW-1:0]   e_addr;
	chs_ent_t            e_wdata, e_rdata;

	logic                do_insert;
	chs_rsp_t            res;
	logic                res_push;
	chs_rsp_t            r0_q, r1_q;
	logic [1:0]          rcnt_q;
	logic                deq;

	assign clearing  = clr_q;
	assign job_take  = (state_q == B_IDLE) & ~clr_q & job_valid & (rcnt_q != 2'd2);
	assign do_insert = (state_q == B_FIN) & (job_q.op == OP_INSERT) & ~hit_q
		& ~count_q[ENT_AW];

	// RAM port steering
	always_comb begin
		h_we    = clr_q | do_insert;
		h_wdata = clr_q ? PTR_NONE : count_q;
		if (clr_q) begin
			h_addr = clr_idx_q;
		end else if (state_q == B_IDLE) begin
			h_addr = job.bucket;
		end else begin
			h_addr = job_q.bucket;
		end
		e_we           = do_insert;
		e_wdata.key    = job_q.key;
		e_wdata.handle = job_q.handle;
		e_wdata.next   = head_q;
		if (state_q == B_HEAD) begin
			e_addr = h_rdata[ENT_AW-1:0];
		end else if (state_q == B_ENT) begin
			e_addr = e_rdata.next[ENT_AW-1:0];
		end else begin
			e_addr = count_q[ENT_AW-1:0];
		end
	end

	chs_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_heads (
		.clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
	);

	chs_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_entries (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
	);

	// chain walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			count_q   <= '0;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + BKT_AW'(1);
				if (clr_idx_q == BKT_AW'(BUCKETS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (do_insert) begin
				count_q <= count_q + PTR_W'(1);
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_take) begin
						state_q <= B_HEAD;
					end
				end
				B_HEAD: begin
					state_q <= h_rdata[ENT_AW] ? B_FIN : B_ENT;
				end
				B_ENT: begin
					if (e_rdata.key == job_q.key || e_rdata.next[ENT_AW]) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job;
			hit_q <= 1'b0;
		end
		if (state_q == B_HEAD) begin
			head_q <= h_rdata;
		end
		if (state_q == B_ENT && e_rdata.key == job_q.key) begin
			hit_q        <= 1'b1;
			hit_handle_q <= e_rdata.handle;
		end
	end

	// result for the finished job
	always_comb begin
		res.found_handle = '0;
		priority if (hit_q && job_q.op == OP_LOOKUP) begin
			res.status       = ST_FOUND;
			res.found_handle = hit_handle_q;
		end else if (hit_q) begin
			res.status = ST_DUPLICATE;
		end else if (job_q.op == OP_LOOKUP) begin
			res.status = ST_NOT_FOUND;
		end else if (count_q[ENT_AW]) begin
			res.status = ST_POOL_FULL;
		end else begin
			res.status = ST_INSERTED;
		end
	end

	assign res_push = state_q == B_FIN;
	assign deq      = pop & (rcnt_q != 2'd0);

	// two-entry result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
		end else begin
			rcnt_q <= rcnt_q + {1'b0, res_push} - {1'b0, deq};
		end
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			r0_q <= (rcnt_q == 2'd2) ? r1_q : res;
			if (res_push) begin
				r1_q <= res;
			end
		end else if (res_push) begin
			if (rcnt_q == 2'd0) begin
				r0_q <= res;
			end else begin
				r1_q <= res;
			end
		end
	end

	assign empty = rcnt_q == 2'd0;
	assign rsp   = r0_q;

endmodule

// ===== hdl/chained_hash_set_core.sv =====
// chained_hash_set_core: hash set with separate chaining over 1024 entries.
// A request runs through the bit-serial modulo unit, then a head read and one entry read
// per chain entry walked, before its result reaches the ports. The front end takes a new
// beat once the previous one is queued as a job, so the modulo of one beat overlaps the
// chain walk of the one before in the back end.
// Reset: clears control state, then a pass writes every bucket head empty with full held
// high; configuration writes are taken throughout.
module chained_hash_set_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  chs_pkg::chs_req_t req,
	output logic              empty,
	input  logic              pop,
	output chs_pkg::chs_rsp_t rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import chs_pkg::*;

	logic [BC_W-1:0] bucket_count_q;
	logic [BC_W-1:0] divisor;
	logic            clearing;
	logic            job_valid;
	logic            job_take;
	chs_job_t        job;

	// configuration register
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {{(32 - BC_W){1'b0}}, bucket_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BC_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			bucket_count_q <= pwdata[BC_W-1:0];
		end
	end

	// zero acts as one, anything above the bucket store as its size
	always_comb begin
		priority if (bucket_count_q == '0) begin
			divisor = BC_W'(1);
		end else if (bucket_count_q > BC_MAX) begin
			divisor = BC_MAX;
		end else begin
			divisor = bucket_count_q;
		end
	end

	chs_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.divisor(divisor), .clearing(clearing),
		.job_valid(job_valid), .job(job), .job_take(job_take)
	);

	chs_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_take(job_take), .clearing(clearing),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

endmodule

// ===== hdl/chs_checker.sv =====
// chs_checker: port-level assertions for chained_hash_set_core, bound in below.
// Uses chs_pkg.
module chs_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  logic              pop,
	input  logic              pready,
	input  chs_pkg::chs_rsp_t rsp
);
	import chs_pkg::*;

	// status code is a defined one whenever a result waits
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> rsp.status <= ST_POOL_FULL)
		else $error("undefined status");

	// handle only returned alongside a hit
	a_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status != ST_FOUND) |-> rsp.found_handle == '0)
		else $error("handle on a miss");

	// waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(rsp)))
		else $error("result dropped or changed");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind chained_hash_set_core chs_checker u_chs_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.pready(pready), .rsp(rsp)
);

// ===== verif/chained_hash_set_core_test.sv =====
// chained_hash_set_core_test: self-checking bench for the chained hash set core.
// Depends on chs_pkg and chained_hash_set_core; keeps its own model of the set.
`timescale 1ns / 100ps

module chained_hash_set_core_test;
	import chs_pkg::*;

	localparam int QUIET_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 1200;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	chs_req_t    req;
	logic        empty;
	logic        pop;
	chs_rsp_t    rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	chained_hash_set_core uut (.*);

	// shadow of the set
	logic [BC_W-1:0]     shadow_bc;
	logic [KEY_W-1:0]    pool_key[ENTRIES];
	logic [HANDLE_W-1:0] pool_handle[ENTRIES];
	int                  pool_next[ENTRIES];   // -1 ends a chain
	int                  chain_head[BUCKETS];  // -1 empty bucket
	int                  pool_used;
	chs_rsp_t            pending_rsp[$];

	// stimulus controls
	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_off;
	int  fail_count;
	int  quiet_cycles;
	bit  timed_out;

	// predict the response of one request and update the shadow
	function automatic chs_rsp_t hash_set_apply(chs_req_t r);
		chs_rsp_t   o;
		int         nb;
		int         b;
		int         cur;
		int         hit;
		int         steps;
		nb = (shadow_bc == 0) ? 1 : ((shadow_bc > BUCKETS) ? BUCKETS : int'(shadow_bc));
		b = int'(r.key % nb);
		cur = chain_head[b];
		hit = -1;
		steps = 0;
		while (cur >= 0 && steps < ENTRIES && hit < 0) begin
			if (pool_key[cur] == r.key)
				hit = cur;
			cur = pool_next[cur];
			steps++;
		end
		o.found_handle = '0;
		if (hit >= 0) begin
			if (r.op == OP_INSERT)
				o.status = ST_DUPLICATE;
			else begin
				o.status = ST_FOUND;
				o.found_handle = pool_handle[hit];
			end
		end else if (r.op == OP_LOOKUP)
			o.status = ST_NOT_FOUND;
		else if (pool_used >= ENTRIES)
			o.status = ST_POOL_FULL;
		else begin
			pool_key[pool_used] = r.key;
			pool_handle[pool_used] = r.entry_handle;
			pool_next[pool_used] = chain_head[b];
			chain_head[b] = pool_used;
			pool_used++;
			o.status = ST_INSERTED;
		end
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, long hold-off on request
	always @(negedge clk) begin
		if (hold_off)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// compare each response beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_rsp.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected response status=%0d handle=%h",
						rsp.status, rsp.found_handle);
			end else begin
				if (rsp !== pending_rsp[0]) begin
					fail_count++;
					if (fail_count <= 10)
						$display({"response: expected status=%0d handle=%h,",
							" got status=%0d handle=%h"},
							pending_rsp[0].status, pending_rsp[0].found_handle,
							rsp.status, rsp.found_handle);
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	// watchdog on cycles with no beat either way
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("chained_hash_set_core: mismatch");
			$finish;
		end
	end

	// push stays high after the beat; the next idle cycle or the drain drops it
	task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [HANDLE_W-1:0] hnd);
		chs_req_t r;
		r.op = op;
		r.key = key;
		r.entry_handle = hnd;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		req <= r;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_rsp.push_back(hash_set_apply(r));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_bucket_count(logic [BC_W-1:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'd0;
		pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		shadow_bc = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [KEY_W-1:0] any_key();
		return KEY_W'({$urandom, $urandom});
	endfunction

	// extremes, both operations, duplicates and the odd bucket counts
	task automatic test_directed();
		send_request(OP_LOOKUP, '0, '1);
		send_request(OP_INSERT, '0, 16'hFFFF);
		send_request(OP_INSERT, '1, 16'h0000);
		send_request(OP_INSERT, '0, 16'h1234);
		send_request(OP_LOOKUP, '0, '0);
		send_request(OP_LOOKUP, '1, '1);
		send_request(OP_INSERT, 31'd1021, 16'h00A5);
		send_request(OP_INSERT, 31'd2042, 16'h5A00);
		send_request(OP_LOOKUP, 31'd1021, '0);
		send_request(OP_LOOKUP, 31'd3063, '0);
		wait_drained();
		write_bucket_count(11'd0);
		send_request(OP_LOOKUP, '0, '0);
		send_request(OP_INSERT, 31'd77, 16'h8001);
		send_request(OP_LOOKUP, 31'd2042, '0);
		wait_drained();
		write_bucket_count(11'h7FF);
		send_request(OP_LOOKUP, 31'd77, '0);
		send_request(OP_INSERT, 31'd1024, 16'h7FFE);
		send_request(OP_LOOKUP, 31'd1024, '0);
		wait_drained();
	endtask

	// inserts and lookups at random, many of them on recently used keys
	task automatic test_random(int n, int key_span);
		logic [KEY_W-1:0] recent[$];
		logic [KEY_W-1:0] k;
		for (int i = 0; i < n; i++) begin
			if (recent.size() != 0 && $urandom_range(99) < 45)
				k = recent[$urandom_range(recent.size() - 1)];
			else if ($urandom_range(3) == 0)
				k = any_key();
			else
				k = KEY_W'($urandom_range(key_span));
			if (recent.size() < 64)
				recent.push_back(k);
			else
				recent[$urandom_range(63)] = k;
			send_request(logic'($urandom_range(1)), k, HANDLE_W'($urandom));
		end
	endtask

	// stall the receiver so the core fills and backs up
	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				for (int c = 0; c < 3000; c++)
					@(negedge clk);
				hold_off = 1'b0;
			end
			test_random(20, 4000);
		join
		wait_drained();
	endtask

	// fill the pool to exhaustion then probe it
	task automatic test_pool_full();
		while (pool_used < ENTRIES)
			send_request(OP_INSERT, any_key(), HANDLE_W'($urandom));
		send_request(OP_INSERT, any_key(), HANDLE_W'($urandom));
		send_request(OP_INSERT, pool_key[0], 16'h0F0F);
		send_request(OP_INSERT, pool_key[ENTRIES-1], 16'h0F0F);
		send_request(OP_LOOKUP, pool_key[ENTRIES-1], '0);
		test_random(40, 1000);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fail_count = 0;
		quiet_cycles = 0;
		timed_out = 1'b0;
		shadow_bc = BC_RESET;
		pool_used = 0;
		for (int i = 0; i < BUCKETS; i++)
			chain_head[i] = -1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		write_bucket_count(11'd1);
		test_random(60, 200);
		wait_drained();
		write_bucket_count(11'd7);
		send_idle_pct = 71;
		test_random(150, 300);
		wait_drained();
		write_bucket_count(11'd1024);
		send_idle_pct = 0;
		recv_stall_pct = 71;
		test_random(150, 5000);
		wait_drained();
		write_bucket_count(11'd257);
		send_idle_pct = 20;
		recv_stall_pct = 20;
		test_random(150, 2000);
		wait_drained();
		recv_stall_pct = 0;
		send_idle_pct = 0;
		test_backpressure();
		write_bucket_count(11'd13);
		test_pool_full();
		write_bucket_count(BC_RESET);
		test_random(60, 3000);
		wait_drained();

		if (fail_count == 0)
			$display("chained_hash_set_core: match");
		else
			$display("chained_hash_set_core: mismatch");
		$finish;
	end

endmodule
